### rtl/core/business_day_counter_macros.svh
// assertion helpers used by the checker file
`ifndef BUSINESS_DAY_COUNTER_MACROS_SVH
`define BUSINESS_DAY_COUNTER_MACROS_SVH

// property checked only while out of reset
`define BDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define BDC_ASSERT_ANY(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/core/bdc_pkg.sv
package bdc_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 15;
    localparam int WDAY_W  = 3;
    localparam int SUM_W   = 15;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int QUEUE_DEPTH = 2;

    // reciprocal constants: y / 100 and x / 7
    localparam int DIV100_PROD_W = YEAR_W + 13;
    localparam int DIV100_SHIFT  = 19;
    localparam int Q100_W        = 8;
    localparam int DIV7_PROD_W   = SUM_W + 16;
    localparam int DIV7_SHIFT    = 18;
    localparam int Q7_W          = DIV7_PROD_W - DIV7_SHIFT;

    localparam logic [DIV100_PROD_W-1:0] DIV100_MUL = DIV100_PROD_W'(5243);
    localparam logic [DIV7_PROD_W-1:0]   DIV7_MUL   = DIV7_PROD_W'(37450);

    localparam logic [WDAY_W-1:0] WD_SUNDAY   = 3'd0;
    localparam logic [WDAY_W-1:0] WD_FRIDAY   = 3'd5;
    localparam logic [WDAY_W-1:0] WD_SATURDAY = 3'd6;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ERR   = 2'd0;
    localparam t_kind KIND_EMPTY = 2'd1;
    localparam t_kind KIND_WALK  = 2'd2;

    typedef struct packed {
        logic [DAY_W-1:0]   from_day;
        logic [MONTH_W-1:0] from_month;
        logic [YEAR_W-1:0]  from_year;
        logic [DAY_W-1:0]   to_day;
        logic [MONTH_W-1:0] to_month;
        logic [YEAR_W-1:0]  to_year;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] business_days;
        logic               count_saturated;
        logic               date_error;
    } t_result;

    typedef struct packed {
        t_kind              kind;
        t_in_item           dates;
        logic [WDAY_W-1:0]  weekday;
        logic               leap;
        logic               leap_next;
    } t_job;

    function automatic logic [Q100_W-1:0] div100(input logic [YEAR_W-1:0] y);
        logic [DIV100_PROD_W-1:0] p;
        p = DIV100_PROD_W'(y) * DIV100_MUL;
        return p[DIV100_PROD_W-1:DIV100_SHIFT];
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [Q100_W-1:0] q;
        logic [YEAR_W-1:0] r;
        q = div100(y);
        r = y - YEAR_W'(q) * YEAR_W'(7'd100);
        return ((y[1:0] == 2'b00) && (r != '0)) || ((r == '0) && (q[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:                                       n = leap ? 5'd29 : 5'd28;
            default:                                    n = 5'd0;
        endcase
        return n;
    endfunction

    // (31 * mm) / 12 of the weekday formula, indexed by calendar month
    function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1:    n = 5'd28;
            4'd2:    n = 5'd31;
            4'd3:    n = 5'd2;
            4'd4:    n = 5'd5;
            4'd5:    n = 5'd7;
            4'd6:    n = 5'd10;
            4'd7:    n = 5'd12;
            4'd8:    n = 5'd15;
            4'd9:    n = 5'd18;
            4'd10:   n = 5'd20;
            4'd11:   n = 5'd23;
            4'd12:   n = 5'd25;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic date_ok(input logic [DAY_W-1:0] d,
                                     input logic [MONTH_W-1:0] m,
                                     input logic [YEAR_W-1:0] y,
                                     input logic leap);
        return (y != '0) && (m >= MONTH_JAN) && (m <= MONTH_DEC) && (d != '0)
            && (d <= month_days(m, leap));
    endfunction

endpackage

### rtl/core/bdc_front.sv
module bdc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bdc_pkg::t_in_item i_item,
    output logic             o_full,
    output logic             o_job_push,
    output bdc_pkg::t_job    o_job,
    input  logic             i_job_full
);
    import bdc_pkg::*;

    localparam logic [2:0] FS_IDLE = 3'd0;
    localparam logic [2:0] FS_DEC  = 3'd1;
    localparam logic [2:0] FS_SUM  = 3'd2;
    localparam logic [2:0] FS_MUL  = 3'd3;
    localparam logic [2:0] FS_PUSH = 3'd4;

    logic [2:0]             r_state, n_state;
    t_in_item               r_item, n_item;
    logic [YEAR_W-1:0]      r_yy, n_yy;
    logic [Q100_W-1:0]      r_q100, n_q100;
    logic                   r_leap_f, n_leap_f;
    logic                   r_leap_t, n_leap_t;
    logic                   r_leap_f1, n_leap_f1;
    t_kind                  r_kind, n_kind;
    logic [SUM_W-1:0]       r_x, n_x;
    logic [DIV7_PROD_W-1:0] r_prod, n_prod;

    logic [Q7_W-1:0]        q7;
    logic [SUM_W-1:0]       wd_full;
    logic                   ok_f, ok_t;

    assign q7      = r_prod[DIV7_PROD_W-1:DIV7_SHIFT];
    assign wd_full = r_x - SUM_W'(q7) * SUM_W'(3'd7);
    assign ok_f    = date_ok(r_item.from_day, r_item.from_month, r_item.from_year, r_leap_f);
    assign ok_t    = date_ok(r_item.to_day, r_item.to_month, r_item.to_year, r_leap_t);

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_yy      = r_yy;
        n_q100    = r_q100;
        n_leap_f  = r_leap_f;
        n_leap_t  = r_leap_t;
        n_leap_f1 = r_leap_f1;
        n_kind    = r_kind;
        n_x       = r_x;
        n_prod    = r_prod;
        unique case (r_state)
            FS_IDLE: begin
                if (i_push) begin
                    n_item  = i_item;
                    n_state = FS_DEC;
                end
            end
            FS_DEC: begin
                // january and february count as months of the year before
                n_yy      = r_item.from_year
                          - YEAR_W'(r_item.from_month <= MONTH_FEB);
                n_q100    = div100(n_yy);
                n_leap_f  = is_leap(r_item.from_year);
                n_leap_t  = is_leap(r_item.to_year);
                n_leap_f1 = is_leap(r_item.from_year + YEAR_W'(1));
                n_state   = FS_SUM;
            end
            FS_SUM: begin
                if (!ok_f || !ok_t) begin
                    n_kind = KIND_ERR;
                end else if ({r_item.to_year, r_item.to_month, r_item.to_day}
                             > {r_item.from_year, r_item.from_month, r_item.from_day}) begin
                    n_kind = KIND_WALK;
                end else begin
                    n_kind = KIND_EMPTY;
                end
                n_x = SUM_W'(r_item.from_day) + SUM_W'(r_yy) + SUM_W'(r_yy >> 2)
                    - SUM_W'(r_q100) + SUM_W'(r_q100 >> 2)
                    + SUM_W'(month_offset(r_item.from_month));
                n_state = FS_MUL;
            end
            FS_MUL: begin
                n_prod  = DIV7_PROD_W'(r_x) * DIV7_MUL;
                n_state = FS_PUSH;
            end
            FS_PUSH: begin
                if (!i_job_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_item    <= n_item;
        r_yy      <= n_yy;
        r_q100    <= n_q100;
        r_leap_f  <= n_leap_f;
        r_leap_t  <= n_leap_t;
        r_leap_f1 <= n_leap_f1;
        r_kind    <= n_kind;
        r_x       <= n_x;
        r_prod    <= n_prod;
    end

    assign o_full            = (r_state != FS_IDLE);
    assign o_job_push        = (r_state == FS_PUSH);
    assign o_job.kind        = r_kind;
    assign o_job.dates       = r_item;
    assign o_job.weekday     = WDAY_W'(wd_full);
    assign o_job.leap        = r_leap_f;
    assign o_job.leap_next   = r_leap_f1;

endmodule

### rtl/core/bdc_queue.sv
module bdc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bdc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output bdc_pkg::t_job o_job,
    output logic          o_empty
);
    import bdc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### rtl/core/bdc_back.sv
module bdc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bdc_pkg::t_job    i_job,
    input  logic             i_job_empty,
    output logic             o_job_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output bdc_pkg::t_result o_result
);
    import bdc_pkg::*;

    localparam logic [1:0] BS_IDLE = 2'd0;
    localparam logic [1:0] BS_WALK = 2'd1;
    localparam logic [1:0] BS_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [DAY_W-1:0]   r_day, n_day;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [DAY_W-1:0]   r_end_day, n_end_day;
    logic [MONTH_W-1:0] r_end_month, n_end_month;
    logic [YEAR_W-1:0]  r_end_year, n_end_year;
    logic [WDAY_W-1:0]  r_wd, n_wd;
    logic               r_leap, n_leap;
    logic               r_leap_next, n_leap_next;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    t_result            r_res, n_res;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               at_end, workday, month_end;

    assign at_end    = {r_year, r_month, r_day} == {r_end_year, r_end_month, r_end_day};
    assign workday   = (r_wd < WD_FRIDAY);
    assign month_end = (r_day == month_days(r_month, r_leap));

    always_comb begin
        n_state     = r_state;
        n_day       = r_day;
        n_month     = r_month;
        n_year      = r_year;
        n_end_day   = r_end_day;
        n_end_month = r_end_month;
        n_end_year  = r_end_year;
        n_wd        = r_wd;
        n_leap      = r_leap;
        n_leap_next = r_leap_next;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_job_pop   = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_res     = '0;
                    n_cnt     = '0;
                    unique case (i_job.kind)
                        KIND_WALK: begin
                            n_day       = i_job.dates.from_day;
                            n_month     = i_job.dates.from_month;
                            n_year      = i_job.dates.from_year;
                            n_end_day   = i_job.dates.to_day;
                            n_end_month = i_job.dates.to_month;
                            n_end_year  = i_job.dates.to_year;
                            n_wd        = i_job.weekday;
                            n_leap      = i_job.leap;
                            n_leap_next = i_job.leap_next;
                            n_state     = BS_WALK;
                        end
                        KIND_ERR: begin
                            n_res.date_error = 1'b1;
                            n_state          = BS_DONE;
                        end
                        default: n_state = BS_DONE;
                    endcase
                end
            end
            BS_WALK: begin
                // leap flag of the following year, ready before the next rollover
                n_leap_next = is_leap(r_year + YEAR_W'(1));
                if (at_end) begin
                    n_res.business_days = r_cnt;
                    n_state             = BS_DONE;
                end else if (workday && (r_cnt == COUNT_MAX)) begin
                    // true count goes past the maximum, no need to walk on
                    n_res.business_days   = COUNT_MAX;
                    n_res.count_saturated = 1'b1;
                    n_state               = BS_DONE;
                end else begin
                    n_cnt = r_cnt + COUNT_W'(workday);
                    n_wd  = (r_wd == WD_SATURDAY) ? WD_SUNDAY : r_wd + WDAY_W'(1);
                    if (month_end) begin
                        n_day = DAY_W'(1);
                        if (r_month == MONTH_DEC) begin
                            n_month = MONTH_JAN;
                            n_year  = r_year + YEAR_W'(1);
                            n_leap  = r_leap_next;
                        end else begin
                            n_month = r_month + MONTH_W'(1);
                        end
                    end else begin
                        n_day = r_day + DAY_W'(1);
                    end
                end
            end
            BS_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_day       <= n_day;
        r_month     <= n_month;
        r_year      <= n_year;
        r_end_day   <= n_end_day;
        r_end_month <= n_end_month;
        r_end_year  <= n_end_year;
        r_wd        <= n_wd;
        r_leap      <= n_leap;
        r_leap_next <= n_leap_next;
        r_cnt       <= n_cnt;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

### rtl/core/business_day_counter.sv
// Counts the days whose weekday is Sunday through Thursday from a start date up
// to, but not including, an end date. Dates are Gregorian; either date being
// invalid gives date_error with a count of 0, and an end date not after the
// start date gives 0. In the back end the date walker advances one calendar day
// per cycle, and stops early once the count passes 32767 (saturated), so it
// walks at most about 45900 days. The front end checks and classifies a request
// in its DEC, SUM, MUL and PUSH states, and the queue can hold two classified
// requests ahead of the walker, so full drops again while a long range is still
// being walked. One result register sits at the output; the walker stalls only
// when it is occupied.
module business_day_counter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  bdc_pkg::t_in_item i_item,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output bdc_pkg::t_result  o_result
);
    import bdc_pkg::*;

    t_job q_in_job, q_out_job;
    logic q_push, q_full, q_pop, q_empty;

    bdc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .o_job_push (q_push),
        .o_job      (q_in_job),
        .i_job_full (q_full)
    );

    bdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_empty (q_empty)
    );

    bdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_out_job),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

### rtl/core/bdc_checker.sv
`include "business_day_counter_macros.svh"

module bdc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             push,
    input logic             full,
    input logic             pop,
    input logic             empty,
    input bdc_pkg::t_result o_result
);
    import bdc_pkg::*;

    `BDC_ASSERT_ANY(a_reset_idle, i_clk, !i_rst_n |=> (empty && !full), "not idle after reset")

    `BDC_ASSERT(a_busy_after_push, i_clk, i_rst_n, (push && !full) |=> full, "front took two transfers")

    `BDC_ASSERT(a_error_zero, i_clk, i_rst_n, (!empty && o_result.date_error) |-> ((o_result.business_days == '0) && !o_result.count_saturated), "error result with nonzero fields")

    `BDC_ASSERT(a_sat_max, i_clk, i_rst_n, (!empty && o_result.count_saturated) |-> (o_result.business_days == COUNT_MAX), "saturated count below maximum")

    `BDC_ASSERT(a_result_held, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_result)), "waiting result changed")

endmodule

bind business_day_counter bdc_checker u_bdc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);
